// ----- hw/rtl/kfil_pkg.sv -----
package kfil_pkg;

    // Field and port widths.
    localparam int KEY_W      = 10;
    localparam int FRAME_W    = 16;
    localparam int TIME_W     = 32;
    localparam int RATIO_W    = 17;
    localparam int FPS_W      = 10;
    localparam int KCNT_W     = 11;
    localparam int TF_W       = TIME_W + FPS_W;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int PC_W       = 4;
    localparam int DIVCNT_W   = 5;

    localparam int MAX_KEYS_DEFAULT = 1024;

    localparam logic [FPS_W-1:0]   FPS_RESET       = 10'd30;
    localparam logic [KCNT_W-1:0]  KEY_COUNT_RESET = 11'd1;
    localparam logic [RATIO_W-1:0] RATIO_ONE       = 17'h10000;

    // The quotient is at most one in Q1.16, so seventeen bits.
    localparam logic [DIVCNT_W-1:0] DIV_STEPS = 5'd17;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FPS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYS = 1'b1;

    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_MUL,
        OP_FIRST,
        OP_NONE,
        OP_IDX1,
        OP_INC,
        OP_SCAN,
        OP_DIVSET,
        OP_DIVSTEP,
        OP_SET_FOUND,
        OP_SET_SINGLE,
        OP_SET_BEFORE,
        OP_SET_AFTER,
        OP_SET_NONE,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_QUERY,
        C_N_ONE,
        C_BEFORE,
        C_AFTER,
        C_SCAN_CONT,
        C_NO_MATCH,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Program addresses.
    localparam logic [PC_W-1:0] S_WAIT       = 4'd0;
    localparam logic [PC_W-1:0] S_MUL        = 4'd1;
    localparam logic [PC_W-1:0] S_FIRST      = 4'd2;
    localparam logic [PC_W-1:0] S_LAST_RD    = 4'd3;
    localparam logic [PC_W-1:0] S_LAST       = 4'd4;
    localparam logic [PC_W-1:0] S_PRIME      = 4'd5;
    localparam logic [PC_W-1:0] S_SCAN       = 4'd6;
    localparam logic [PC_W-1:0] S_DISPATCH   = 4'd7;
    localparam logic [PC_W-1:0] S_DIV        = 4'd8;
    localparam logic [PC_W-1:0] S_SET_FOUND  = 4'd9;
    localparam logic [PC_W-1:0] S_SET_SINGLE = 4'd10;
    localparam logic [PC_W-1:0] S_SET_BEFORE = 4'd11;
    localparam logic [PC_W-1:0] S_SET_AFTER  = 4'd12;
    localparam logic [PC_W-1:0] S_SET_NONE   = 4'd13;
    localparam logic [PC_W-1:0] S_SPARE      = 4'd14;
    localparam logic [PC_W-1:0] S_EMIT       = 4'd15;

    // Control store. A word jumps to its target when its condition holds,
    // otherwise it falls through to the next address. The last word wraps
    // back to the wait step.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            S_WAIT:       w = '{op: OP_ACCEPT,     cond: C_NO_QUERY,  target: S_WAIT};
            S_MUL:        w = '{op: OP_MUL,        cond: C_N_ONE,     target: S_SET_SINGLE};
            S_FIRST:      w = '{op: OP_FIRST,      cond: C_BEFORE,    target: S_SET_BEFORE};
            S_LAST_RD:    w = '{op: OP_NONE,       cond: C_NEVER,     target: S_WAIT};
            S_LAST:       w = '{op: OP_IDX1,       cond: C_AFTER,     target: S_SET_AFTER};
            S_PRIME:      w = '{op: OP_INC,        cond: C_NEVER,     target: S_WAIT};
            S_SCAN:       w = '{op: OP_SCAN,       cond: C_SCAN_CONT, target: S_SCAN};
            S_DISPATCH:   w = '{op: OP_DIVSET,     cond: C_NO_MATCH,  target: S_SET_NONE};
            S_DIV:        w = '{op: OP_DIVSTEP,    cond: C_DIV_MORE,  target: S_DIV};
            S_SET_FOUND:  w = '{op: OP_SET_FOUND,  cond: C_ALWAYS,    target: S_EMIT};
            S_SET_SINGLE: w = '{op: OP_SET_SINGLE, cond: C_ALWAYS,    target: S_EMIT};
            S_SET_BEFORE: w = '{op: OP_SET_BEFORE, cond: C_ALWAYS,    target: S_EMIT};
            S_SET_AFTER:  w = '{op: OP_SET_AFTER,  cond: C_ALWAYS,    target: S_EMIT};
            S_SET_NONE:   w = '{op: OP_SET_NONE,   cond: C_ALWAYS,    target: S_EMIT};
            S_EMIT:       w = '{op: OP_EMIT,       cond: C_OUT_BUSY,  target: S_EMIT};
            default:      w = '{op: OP_NONE,       cond: C_ALWAYS,    target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/keyframe_interval_lookup.sv -----
// Key-frame interval lookup.
//
// Input stream (i_s_*): each transfer is either a load or a query, chosen by
// i_s_tuser. A load writes one key-frame number into the table; the block
// is ready again in the next cycle. A query takes the time t (Q16.16
// seconds), scales it by the frame rate and returns the pair of neighboring
// keys around it together with the Q1.16 blend ratio.
// Output stream (o_m_*): one transfer per query, none per load.
// Configuration (i_cfg_*): register 0 is the frame rate, register 1 is the
// number of keys in use. The port is always ready; write it while idle.
// A single-key query skips the table. Otherwise the control program first
// checks key 0 and the last key in use, then scans the table one key per
// cycle through the single read port of the key RAM and, on a match, runs
// a 17-step restoring divider. Queries are worked one at a time.
// A finished result sits in the output register while the next item is
// taken; if the receiver stalls, the program waits at its emit step.
// Reset restores the frame rate to 30 and the key count to 1 and empties the
// output register. The key table is not cleared: load every key before use.
module keyframe_interval_lookup #(
    parameter int MAX_KEYS = kfil_pkg::MAX_KEYS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: key_index[9:0], key_frame[25:10], query_time[57:26], zeros above.
    input  logic [kfil_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // tuser: action[0] (0 load, 1 query).
    input  logic                              i_s_tuser,
    // Output stream.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: first_key[9:0], second_key[19:10], blend_ratio[36:20], zeros above.
    output logic [kfil_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // tuser: found[0].
    output logic                              o_m_tuser,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kfil_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kfil_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int CW = (NW > kfil_pkg::KCNT_W) ? NW : kfil_pkg::KCNT_W;
    localparam int XW = AW + kfil_pkg::KEY_W;
    localparam int KW = kfil_pkg::KEY_W;
    localparam int FW = kfil_pkg::FRAME_W;
    localparam int TW = kfil_pkg::TF_W;
    localparam int RW = kfil_pkg::RATIO_W;

    // Reduce a table index to the 10-bit result field.
    function automatic logic [KW-1:0] to_key(input logic [NW-1:0] v);
        logic [NW+KW-1:0] w;
        w = (NW + KW)'(v);
        return w[KW-1:0];
    endfunction

    // Input field unpacking.
    logic                          w_action;
    logic [KW-1:0]                 w_key_index;
    logic [FW-1:0]                 w_key_frame;
    logic [kfil_pkg::TIME_W-1:0]   w_query_time;

    assign w_action     = i_s_tuser;
    assign w_key_index  = i_s_tdata[9:0];
    assign w_key_frame  = i_s_tdata[25:10];
    assign w_query_time = i_s_tdata[57:26];

    // Sequencer.
    logic [kfil_pkg::PC_W-1:0] r_pc, n_pc;
    kfil_pkg::t_uword          w_uw;
    logic                      w_cond;

    assign w_uw = kfil_pkg::ucode(r_pc);

    // Configuration registers.
    logic [kfil_pkg::FPS_W-1:0]  r_fps;
    logic [kfil_pkg::KCNT_W-1:0] r_key_count;

    // Datapath registers.
    logic [kfil_pkg::TIME_W-1:0] r_qt;
    logic [TW-1:0]               r_tf;
    logic [NW-1:0]               r_n;
    logic [NW-1:0]               r_idx;
    logic [FW-1:0]               r_lo;
    logic [FW-1:0]               r_hi;
    logic                        r_match;
    logic [FW-1:0]               r_span;
    logic [RW-1:0]               r_rem;
    logic [RW-1:0]               r_dq;
    logic [RW-1:0]               r_q;
    logic [kfil_pkg::DIVCNT_W-1:0] r_cnt;

    // Staged result, then the output register.
    logic [KW-1:0] r_res_first, r_res_second;
    logic [RW-1:0] r_res_ratio;
    logic          r_res_found;
    logic          r_out_valid;
    logic [KW-1:0] r_o_first, r_o_second;
    logic [RW-1:0] r_o_ratio;
    logic          r_o_found;

    // Handshakes.
    logic w_s_xfer, w_query_xfer, w_load_xfer, w_out_free;

    assign o_s_tready   = (w_uw.op == kfil_pkg::OP_ACCEPT);
    assign w_s_xfer     = i_s_tvalid && o_s_tready;
    assign w_query_xfer = w_s_xfer && (w_action == kfil_pkg::ACT_QUERY);
    assign w_load_xfer  = w_s_xfer && (w_action == kfil_pkg::ACT_LOAD);
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign o_cfg_ready  = 1'b1;

    // Key table. A load beyond the table size is dropped.
    logic [XW-1:0] w_kidx_ext;
    logic          w_we;
    logic [FW-1:0] w_rd;

    assign w_kidx_ext = XW'(w_key_index);
    assign w_we       = w_load_xfer && (w_kidx_ext < XW'(MAX_KEYS));

    kfil_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_kidx_ext[AW-1:0]),
        .i_wdata (w_key_frame),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rd)
    );

    // Effective frame rate and key count.
    logic [kfil_pkg::FPS_W-1:0] w_fps;
    logic [CW-1:0]              w_kc;
    logic [CW-1:0]              w_n_wide;

    assign w_fps    = (r_fps == '0) ? kfil_pkg::FPS_W'(1) : r_fps;
    assign w_kc     = CW'(r_key_count);
    assign w_n_wide = (w_kc == '0) ? CW'(1) :
                      (w_kc > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : w_kc;

    // Compares of the scaled time against key frames in Q16.16.
    logic [TW-1:0] w_prod, w_rd_q, w_lo_q, w_diff;
    logic          w_match;

    assign w_prod  = TW'(r_qt) * TW'(w_fps);
    assign w_rd_q  = TW'({w_rd, 16'h0000});
    assign w_lo_q  = TW'({r_lo, 16'h0000});
    assign w_match = (r_tf >= w_lo_q) && (w_rd_q >= r_tf);
    assign w_diff  = r_tf - w_lo_q;

    // One restoring division step.
    logic [RW-1:0] w_trial, w_span_x;
    logic          w_ge;

    assign w_trial  = {r_rem[RW-2:0], r_dq[RW-1]};
    assign w_span_x = RW'(r_span);
    assign w_ge     = (w_trial >= w_span_x);

    // Branch condition.
    always_comb begin
        case (w_uw.cond)
            kfil_pkg::C_NEVER:     w_cond = 1'b0;
            kfil_pkg::C_ALWAYS:    w_cond = 1'b1;
            kfil_pkg::C_NO_QUERY:  w_cond = !w_query_xfer;
            kfil_pkg::C_N_ONE:     w_cond = (r_n == NW'(1));
            kfil_pkg::C_BEFORE:    w_cond = (w_rd_q > r_tf);
            kfil_pkg::C_AFTER:     w_cond = (r_tf > w_rd_q);
            kfil_pkg::C_SCAN_CONT: w_cond = !w_match && (r_idx != r_n);
            kfil_pkg::C_NO_MATCH:  w_cond = !r_match;
            kfil_pkg::C_DIV_MORE:  w_cond = (r_cnt != kfil_pkg::DIVCNT_W'(1));
            kfil_pkg::C_OUT_BUSY:  w_cond = !w_out_free;
            default:               w_cond = 1'b0;
        endcase
    end

    assign n_pc = w_cond ? w_uw.target : r_pc + kfil_pkg::PC_W'(1);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= kfil_pkg::S_WAIT;
            r_out_valid <= 1'b0;
            r_fps       <= kfil_pkg::FPS_RESET;
            r_key_count <= kfil_pkg::KEY_COUNT_RESET;
        end else begin
            r_pc <= n_pc;
            if (w_uw.op == kfil_pkg::OP_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    kfil_pkg::CFG_FPS:  r_fps       <= i_cfg_data[kfil_pkg::FPS_W-1:0];
                    kfil_pkg::CFG_KEYS: r_key_count <= i_cfg_data[kfil_pkg::KCNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath, driven by the operation field of the current control word.
    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            kfil_pkg::OP_ACCEPT: begin
                r_idx <= '0;
                if (w_query_xfer) begin
                    r_qt <= w_query_time;
                    r_n  <= NW'(w_n_wide);
                end
            end
            kfil_pkg::OP_MUL: begin
                r_tf <= w_prod;
            end
            kfil_pkg::OP_FIRST: begin
                // Frame of key 0 arrives; next read the last key in use.
                r_lo  <= w_rd;
                r_idx <= r_n - NW'(1);
            end
            kfil_pkg::OP_IDX1: begin
                r_idx <= NW'(1);
            end
            kfil_pkg::OP_INC: begin
                r_idx <= r_idx + NW'(1);
            end
            kfil_pkg::OP_SCAN: begin
                // The frame of key r_idx-1 is on the read port.
                r_match <= w_match;
                if (w_match) begin
                    r_hi <= w_rd;
                end else begin
                    r_lo  <= w_rd;
                    r_idx <= r_idx + NW'(1);
                end
            end
            kfil_pkg::OP_DIVSET: begin
                // The offset is at most span * 2^16, so it fits 32 bits and
                // its bits above the quotient width are already below span.
                r_span <= r_hi - r_lo;
                r_rem  <= RW'(w_diff[31:17]);
                r_dq   <= w_diff[16:0];
                r_q    <= '0;
                r_cnt  <= kfil_pkg::DIV_STEPS;
            end
            kfil_pkg::OP_DIVSTEP: begin
                r_rem <= w_ge ? (w_trial - w_span_x) : w_trial;
                r_dq  <= {r_dq[RW-2:0], 1'b0};
                r_q   <= {r_q[RW-2:0], w_ge};
                r_cnt <= r_cnt - kfil_pkg::DIVCNT_W'(1);
            end
            kfil_pkg::OP_SET_FOUND: begin
                r_res_first  <= to_key(r_idx - NW'(2));
                r_res_second <= to_key(r_idx - NW'(1));
                r_res_ratio  <= (r_span == '0) ? '0 : r_q;
                r_res_found  <= 1'b1;
            end
            kfil_pkg::OP_SET_SINGLE: begin
                r_res_first  <= '0;
                r_res_second <= '0;
                r_res_ratio  <= '0;
                r_res_found  <= 1'b1;
            end
            kfil_pkg::OP_SET_BEFORE: begin
                r_res_first  <= '0;
                r_res_second <= KW'(1);
                r_res_ratio  <= '0;
                r_res_found  <= 1'b1;
            end
            kfil_pkg::OP_SET_AFTER: begin
                r_res_first  <= to_key(r_n - NW'(2));
                r_res_second <= to_key(r_n - NW'(1));
                r_res_ratio  <= kfil_pkg::RATIO_ONE;
                r_res_found  <= 1'b1;
            end
            kfil_pkg::OP_SET_NONE: begin
                r_res_first  <= '0;
                r_res_second <= '0;
                r_res_ratio  <= '0;
                r_res_found  <= 1'b0;
            end
            kfil_pkg::OP_EMIT: begin
                if (w_out_free) begin
                    r_o_first  <= r_res_first;
                    r_o_second <= r_res_second;
                    r_o_ratio  <= r_res_ratio;
                    r_o_found  <= r_res_found;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_o_ratio, r_o_second, r_o_first};
    assign o_m_tuser  = r_o_found;

endmodule

// ----- hw/rtl/kfil_ram.sv -----
module kfil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/kfil_checker.sv -----
module kfil_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [kfil_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic                           o_m_tuser
);

    logic w_query_xfer, w_load_xfer;

    assign w_query_xfer = i_s_tvalid && o_s_tready && (i_s_tuser == kfil_pkg::ACT_QUERY);
    assign w_load_xfer  = i_s_tvalid && o_s_tready && (i_s_tuser == kfil_pkg::ACT_LOAD);

    // A query occupies the sequencer, so input is closed right after it.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query_xfer |=> !o_s_tready)
        else $error("input still ready after a query transfer");

    // A load completes in its own cycle.
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_xfer |=> o_s_tready)
        else $error("input not ready after a load transfer");

    // No result can appear in the cycle right after a query is taken.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query_xfer |=> !$rose(o_m_tvalid))
        else $error("result appeared too early after a query");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind keyframe_interval_lookup kfil_checker u_kfil_checker (.*);
